>>> rtl/ppplcp_pkg.sv
`timescale 1ns / 1ps

package ppplcp_pkg;

    // Link states of the control automaton; codes 10 to 15 are never entered.
    typedef enum logic [3:0] {
        ST_INITIAL  = 4'd0,
        ST_STARTING = 4'd1,
        ST_CLOSED   = 4'd2,
        ST_STOPPED  = 4'd3,
        ST_CLOSING  = 4'd4,
        ST_STOPPING = 4'd5,
        ST_REQSENT  = 4'd6,
        ST_ACKRCVD  = 4'd7,
        ST_ACKSENT  = 4'd8,
        ST_OPENED   = 4'd9
    } link_state_t;

    // Event kinds carried on the input tuser.
    typedef enum logic [2:0] {
        EV_OPEN           = 3'd0,
        EV_CLOSE          = 3'd1,
        EV_PACKET         = 3'd2,
        EV_LOWER_UP       = 3'd3,
        EV_LOWER_DOWN     = 3'd4,
        EV_UPPER_STARTED  = 3'd5,
        EV_UPPER_FINISHED = 3'd6,
        EV_TIMEOUT        = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        TMR_NONE  = 2'd0,
        TMR_START = 2'd1,
        TMR_STOP  = 2'd2
    } timer_cmd_t;

    typedef enum logic [2:0] {
        SIG_NONE     = 3'd0,
        SIG_UP       = 3'd1,
        SIG_DOWN     = 3'd2,
        SIG_STARTED  = 3'd3,
        SIG_FINISHED = 3'd4
    } layer_sig_t;

    // LCP packet codes.
    localparam logic [7:0] CODE_CONF_REQ  = 8'd1;
    localparam logic [7:0] CODE_CONF_ACK  = 8'd2;
    localparam logic [7:0] CODE_CONF_NAK  = 8'd3;
    localparam logic [7:0] CODE_CONF_REJ  = 8'd4;
    localparam logic [7:0] CODE_TERM_REQ  = 8'd5;
    localparam logic [7:0] CODE_TERM_ACK  = 8'd6;
    localparam logic [7:0] CODE_CODE_REJ  = 8'd7;
    localparam logic [7:0] CODE_PROTO_REJ = 8'd8;

    localparam logic [15:0] MIN_PACKET_LENGTH = 16'd4;

    // Configuration register indexes.
    localparam logic CFG_MAX_CONFIGURE = 1'b0;
    localparam logic CFG_MAX_TERMINATE = 1'b1;

    localparam logic [7:0] MAX_CONFIGURE_RESET = 8'd10;
    localparam logic [7:0] MAX_TERMINATE_RESET = 8'd2;

    // Input item payload, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]  pad;
        logic        reply_buffer_busy;
        logic        request_buffer_busy;
        logic [15:0] packet_length;
        logic [7:0]  packet_code;
    } in_data_t;

    // Result item payload, last field in the lowest bits.
    typedef struct packed {
        logic [7:0]  packet_identifier;
        logic        protocol_rejected;
        layer_sig_t  layer_signal;
        timer_cmd_t  timer_command;
        logic        emit_code_rej;
        logic        emit_term_ack;
        logic        emit_term_req;
        logic        send_config_ack;
        logic        send_config_request;
        logic        event_error;
        link_state_t new_state;
    } result_t;

    // Persistent automaton context.
    typedef struct packed {
        link_state_t state;
        logic [7:0]  restart_counter;
        logic [7:0]  next_identifier;
    } ctx_t;

endpackage

>>> rtl/ppplcp_step.sv
`timescale 1ns / 1ps

module ppplcp_step (
    input  ppplcp_pkg::ctx_t     ctx,
    input  logic [7:0]           max_configure,
    input  logic [7:0]           max_terminate,
    input  ppplcp_pkg::event_t   ev,
    input  ppplcp_pkg::in_data_t data,
    output ppplcp_pkg::ctx_t     ctx_next,
    output ppplcp_pkg::result_t  res
);
    import ppplcp_pkg::*;

    // Transition table: collect requested actions, then resolve buffer gating.
    always_comb
    begin
        link_state_t st_n;
        logic [7:0]  cnt_n;
        logic        want_scr;
        logic        want_sca;
        logic        want_str;
        logic        want_sta;
        logic        want_scj;
        logic        tmr_stop;
        layer_sig_t  sig;
        logic        err;
        logic        prej;
        logic        go_str;
        logic        go_sta;
        logic        go_scj;

        st_n     = ctx.state;
        cnt_n    = ctx.restart_counter;
        want_scr = 1'b0;
        want_sca = 1'b0;
        want_str = 1'b0;
        want_sta = 1'b0;
        want_scj = 1'b0;
        tmr_stop = 1'b0;
        sig      = SIG_NONE;
        err      = 1'b0;
        prej     = 1'b0;

        case (ev)
            EV_OPEN:
            begin
                case (ctx.state)
                    ST_INITIAL:
                    begin
                        sig  = SIG_STARTED;
                        st_n = ST_STARTING;
                    end
                    ST_CLOSED:
                    begin
                        cnt_n    = max_configure;
                        want_scr = 1'b1;
                        st_n     = ST_REQSENT;
                    end
                    ST_CLOSING: st_n = ST_STOPPING;
                    default:    err  = 1'b1;
                endcase
            end
            EV_CLOSE:
            begin
                case (ctx.state)
                    ST_STARTING:
                    begin
                        sig  = SIG_FINISHED;
                        st_n = ST_INITIAL;
                    end
                    ST_STOPPED:  st_n = ST_CLOSED;
                    ST_STOPPING: st_n = ST_CLOSING;
                    ST_OPENED, ST_REQSENT, ST_ACKRCVD, ST_ACKSENT:
                    begin
                        if (ctx.state == ST_OPENED)
                        begin
                            sig = SIG_DOWN;
                        end
                        cnt_n    = max_terminate;
                        want_str = 1'b1;
                        st_n     = ST_CLOSING;
                    end
                    default: err = 1'b1;
                endcase
            end
            EV_PACKET:
            begin
                if (data.packet_length < MIN_PACKET_LENGTH)
                begin
                    err = 1'b1;
                end
                else
                begin
                    case (data.packet_code)
                        CODE_CONF_REQ:
                        begin
                            case (ctx.state)
                                ST_CLOSED: want_sta = 1'b1;
                                ST_STOPPED:
                                begin
                                    cnt_n    = max_configure;
                                    want_scr = 1'b1;
                                    want_sca = 1'b1;
                                    st_n     = ST_ACKSENT;
                                end
                                ST_REQSENT, ST_ACKSENT:
                                begin
                                    want_sca = 1'b1;
                                    st_n     = ST_ACKSENT;
                                end
                                ST_ACKRCVD:
                                begin
                                    want_sca = 1'b1;
                                    tmr_stop = 1'b1;
                                    st_n     = ST_OPENED;
                                    sig      = SIG_UP;
                                end
                                ST_OPENED:
                                begin
                                    sig      = SIG_DOWN;
                                    want_scr = 1'b1;
                                    want_sca = 1'b1;
                                    st_n     = ST_ACKSENT;
                                end
                                default: ;
                            endcase
                        end
                        CODE_CONF_ACK:
                        begin
                            case (ctx.state)
                                ST_CLOSED, ST_STOPPED: want_sta = 1'b1;
                                ST_REQSENT:
                                begin
                                    cnt_n = max_configure;
                                    st_n  = ST_ACKRCVD;
                                end
                                ST_ACKRCVD:
                                begin
                                    want_scr = 1'b1;
                                    st_n     = ST_REQSENT;
                                end
                                ST_ACKSENT:
                                begin
                                    cnt_n    = max_configure;
                                    tmr_stop = 1'b1;
                                    st_n     = ST_OPENED;
                                    sig      = SIG_UP;
                                end
                                ST_OPENED:
                                begin
                                    sig      = SIG_DOWN;
                                    want_scr = 1'b1;
                                    st_n     = ST_REQSENT;
                                end
                                default: ;
                            endcase
                        end
                        CODE_CONF_NAK, CODE_CONF_REJ:
                        begin
                            case (ctx.state)
                                ST_CLOSED, ST_STOPPED: want_sta = 1'b1;
                                ST_REQSENT:
                                begin
                                    cnt_n    = max_configure;
                                    want_scr = 1'b1;
                                end
                                ST_ACKRCVD:
                                begin
                                    want_scr = 1'b1;
                                    st_n     = ST_REQSENT;
                                end
                                ST_ACKSENT:
                                begin
                                    cnt_n    = max_configure;
                                    want_scr = 1'b1;
                                end
                                ST_OPENED:
                                begin
                                    sig      = SIG_DOWN;
                                    want_scr = 1'b1;
                                    st_n     = ST_REQSENT;
                                end
                                default: ;
                            endcase
                        end
                        CODE_TERM_REQ:
                        begin
                            case (ctx.state)
                                ST_CLOSED, ST_STOPPED, ST_CLOSING, ST_STOPPING:
                                    want_sta = 1'b1;
                                ST_REQSENT, ST_ACKRCVD, ST_ACKSENT:
                                begin
                                    want_sta = 1'b1;
                                    st_n     = ST_REQSENT;
                                end
                                ST_OPENED:
                                begin
                                    sig      = SIG_DOWN;
                                    cnt_n    = 8'd0;
                                    want_sta = 1'b1;
                                    st_n     = ST_STOPPING;
                                end
                                default: ;
                            endcase
                        end
                        CODE_TERM_ACK:
                        begin
                            case (ctx.state)
                                ST_CLOSING:
                                begin
                                    tmr_stop = 1'b1;
                                    sig      = SIG_DOWN;
                                    st_n     = ST_CLOSED;
                                end
                                ST_STOPPING:
                                begin
                                    tmr_stop = 1'b1;
                                    st_n     = ST_STOPPED;
                                end
                                ST_OPENED:
                                begin
                                    sig      = SIG_DOWN;
                                    want_scr = 1'b1;
                                    st_n     = ST_REQSENT;
                                end
                                ST_ACKRCVD: st_n = ST_REQSENT;
                                default: ;
                            endcase
                        end
                        CODE_CODE_REJ:
                        begin
                            case (ctx.state)
                                ST_CLOSING:
                                begin
                                    tmr_stop = 1'b1;
                                    st_n     = ST_CLOSED;
                                end
                                ST_STOPPING, ST_REQSENT, ST_ACKRCVD, ST_ACKSENT:
                                begin
                                    tmr_stop = 1'b1;
                                    st_n     = ST_STOPPED;
                                end
                                ST_OPENED:
                                begin
                                    sig      = SIG_DOWN;
                                    cnt_n    = max_terminate;
                                    want_str = 1'b1;
                                    st_n     = ST_STOPPING;
                                end
                                default: ;
                            endcase
                        end
                        CODE_PROTO_REJ: prej = 1'b1;
                        default:        want_scj = 1'b1;
                    endcase
                end
            end
            EV_LOWER_UP:
            begin
                case (ctx.state)
                    ST_INITIAL:
                    begin
                        tmr_stop = 1'b1;
                        st_n     = ST_CLOSED;
                    end
                    ST_STARTING:
                    begin
                        cnt_n    = max_configure;
                        want_scr = 1'b1;
                        st_n     = ST_REQSENT;
                    end
                    default: ;
                endcase
            end
            EV_LOWER_DOWN:
            begin
                case (ctx.state)
                    ST_CLOSED, ST_CLOSING:
                    begin
                        tmr_stop = 1'b1;
                        st_n     = ST_INITIAL;
                    end
                    ST_STOPPED, ST_STOPPING, ST_REQSENT, ST_ACKRCVD, ST_ACKSENT,
                    ST_OPENED:
                    begin
                        sig      = SIG_DOWN;
                        tmr_stop = 1'b1;
                        st_n     = ST_STARTING;
                    end
                    default: ;
                endcase
            end
            EV_UPPER_STARTED:
            begin
                case (ctx.state)
                    ST_INITIAL: st_n = ST_STARTING;
                    ST_CLOSED:
                    begin
                        cnt_n    = max_configure;
                        want_scr = 1'b1;
                        st_n     = ST_REQSENT;
                    end
                    ST_CLOSING: st_n = ST_STOPPING;
                    default: ;
                endcase
            end
            EV_UPPER_FINISHED:
            begin
                case (ctx.state)
                    ST_STARTING: st_n = ST_INITIAL;
                    ST_STOPPED:  st_n = ST_CLOSED;
                    ST_STOPPING: st_n = ST_CLOSING;
                    ST_OPENED, ST_REQSENT, ST_ACKRCVD, ST_ACKSENT:
                    begin
                        cnt_n    = max_terminate;
                        want_str = 1'b1;
                        st_n     = ST_CLOSING;
                    end
                    default: ;
                endcase
            end
            EV_TIMEOUT:
            begin
                if (ctx.restart_counter != 8'd0)
                begin
                    // Retransmit: the counter counts down in every state.
                    cnt_n = ctx.restart_counter - 8'd1;
                    case (ctx.state)
                        ST_CLOSING, ST_STOPPING: want_str = 1'b1;
                        ST_REQSENT, ST_ACKRCVD:
                        begin
                            want_scr = 1'b1;
                            st_n     = ST_REQSENT;
                        end
                        ST_ACKSENT: want_scr = 1'b1;
                        default: ;
                    endcase
                end
                else
                begin
                    // Retries exhausted: give up.
                    case (ctx.state)
                        ST_CLOSING:
                        begin
                            st_n = ST_CLOSED;
                            sig  = SIG_FINISHED;
                        end
                        ST_STOPPING, ST_REQSENT, ST_ACKRCVD, ST_ACKSENT:
                        begin
                            st_n = ST_STOPPED;
                            sig  = SIG_FINISHED;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        // Terminate and code-reject sends that would land in a busy buffer are dropped.
        go_str = want_str & ~data.request_buffer_busy;
        go_sta = want_sta & ~data.reply_buffer_busy;
        go_scj = want_scj & ~data.reply_buffer_busy;

        ctx_next.state           = st_n;
        ctx_next.restart_counter = cnt_n;
        ctx_next.next_identifier = (go_str || go_sta) ? ctx.next_identifier + 8'd1
                                                      : ctx.next_identifier;

        res.new_state           = st_n;
        res.event_error         = err;
        res.send_config_request = want_scr;
        res.send_config_ack     = want_sca;
        res.emit_term_req       = go_str;
        res.emit_term_ack       = go_sta;
        res.emit_code_rej       = go_scj;
        res.layer_signal        = sig;
        res.protocol_rejected   = prej;
        res.packet_identifier   = (go_str || go_sta) ? ctx.next_identifier : 8'd0;

        // No event both starts and stops the timer.
        if (want_scr || go_str || go_sta)
        begin
            res.timer_command = TMR_START;
        end
        else if (tmr_stop)
        begin
            res.timer_command = TMR_STOP;
        end
        else
        begin
            res.timer_command = TMR_NONE;
        end
    end

endmodule

>>> rtl/ppp_lcp_option_negotiation_fsm.sv
`timescale 1ns / 1ps
// An accepted item waits in the input register and moves to the result register when that
// register is free or being drained; the result is then shown on the output.
// Throughput: one item per cycle while the output is not stalled; the link context updates
// as an item moves from the input register to the result register, so each item sees the
// state its predecessor left. Reset (rst_n low, asynchronous): both stages empty, link
// state initial, restart counter and identifier zero, max_configure 10 and max_terminate 2.

module ppp_lcp_option_negotiation_fsm (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // packet_code, packet_length, request_buffer_busy,
                                   // reply_buffer_busy, zero fill
    input  logic [2:0]  s_tuser,   // req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // new_state, event_error, send_config_request,
                                   // send_config_ack, emit_term_req,
                                   // emit_term_ack, emit_code_rej, timer_command,
                                   // layer_signal, protocol_rejected, packet_identifier

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import ppplcp_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    event_t     in_ev_reg;
    in_data_t   in_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    res_reg;
    result_t    nxt_res;
    ctx_t       ctx_reg;
    ctx_t       ctx_next;
    logic [7:0] max_configure_reg;
    logic [7:0] max_terminate_reg;
    logic       advance;
    logic       in_take;

    // Move an item forward when the result register is free or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : ((out_valid_reg && m_tready) ? 1'b0
                                                                          : out_valid_reg);

    ppplcp_step u_step (
        .ctx           (ctx_reg),
        .max_configure (max_configure_reg),
        .max_terminate (max_terminate_reg),
        .ev            (in_ev_reg),
        .data          (in_data_reg),
        .ctx_next      (ctx_next),
        .res           (nxt_res)
    );

    // Pipeline control and link context.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg.state           <= ST_INITIAL;
            ctx_reg.restart_counter <= 8'd0;
            ctx_reg.next_identifier <= 8'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                ctx_reg <= ctx_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ev_reg   <= event_t'(s_tuser);
            in_data_reg <= in_data_t'(s_tdata);
        end
        if (advance)
        begin
            res_reg <= nxt_res;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_configure_reg <= MAX_CONFIGURE_RESET;
            max_terminate_reg <= MAX_TERMINATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_CONFIGURE)
            begin
                max_configure_reg <= cfg_data;
            end
            else
            begin
                max_terminate_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

`ifndef SYNTHESIS
    // The link context only changes when an item is processed.
    a_ctx_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (ctx_reg != $past(ctx_reg)) |-> $past(advance))
        else $error("link context changed without an item");

    // The identifier moves on only when a terminate packet goes out.
    a_ident_use: assert property (@(posedge clk) disable iff (!rst_n)
        (ctx_reg.next_identifier != $past(ctx_reg.next_identifier)) |->
        $past(advance && (nxt_res.emit_term_req || nxt_res.emit_term_ack)))
        else $error("identifier advanced without a terminate send");

    // A nonzero identifier only accompanies a terminate send.
    a_ident_field: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_reg.packet_identifier != 8'd0)) |->
        (res_reg.emit_term_req || res_reg.emit_term_ack))
        else $error("identifier reported without a terminate send");

    // One event never emits both terminate packets.
    a_one_term: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res_reg.emit_term_req && res_reg.emit_term_ack))
        else $error("terminate request and ack in one result");

    // Input side only stalls while an item is held.
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked item");
`endif

endmodule
